/* design/wvd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvd_pkg
// Shared widths, codes and control types for the window velocity block.
// ----------------------------------------------------------------------------
package wvd_pkg;

  localparam int POS_W          = 22;
  localparam int RATE_W         = 10;
  localparam int VEL_W          = 32;
  localparam int SQ_W           = 2 * POS_W;
  localparam int ROOT_W         = POS_W;
  localparam int NSUM_W         = 28;
  localparam int MEAN_W         = 22;
  localparam int DIR_W          = 2;
  localparam int DIV_N          = VEL_W;
  localparam int STEP_W         = $clog2(DIV_N);
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100);

  localparam logic [DIR_W-1:0] DIR_FLAT = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_ROOT,
    ST_ACC,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic store;
    logic first;
    logic rad_load;
    logic root_step;
    logic acc;
    logic mul;
    logic div_load;
    logic div_step;
    logic close;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

/* design/wvd_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvd_ifs
// Valid/ready channels: sample input, result output and rate register write.
// ----------------------------------------------------------------------------
interface wvd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [wvd_pkg::POS_W-1:0] pos_x;
  logic signed [wvd_pkg::POS_W-1:0] pos_y;
  logic signed [wvd_pkg::POS_W-1:0] pos_z;
  logic                             window_end;
  modport source (output valid, pos_x, pos_y, pos_z, window_end, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, window_end, output ready);
endinterface

interface wvd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wvd_pkg::VEL_W-1:0]  vel_x;
  logic signed [wvd_pkg::VEL_W-1:0]  vel_y;
  logic signed [wvd_pkg::VEL_W-1:0]  vel_z;
  logic        [wvd_pkg::MEAN_W-1:0] mean_distance;
  logic signed [wvd_pkg::DIR_W-1:0]  direction;
  modport source (output valid, vel_x, vel_y, vel_z, mean_distance, direction,
                  input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, mean_distance, direction,
                output ready);
endinterface

interface wvd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wvd_pkg::RATE_W-1:0]  sample_rate_hz;
  modport source (output valid, sample_rate_hz, input ready);
  modport sink (input valid, sample_rate_hz, output ready);
endinterface

/* design/wvd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvd_div
// Serial restoring divider, one quotient bit per step, unsigned operands.
// ----------------------------------------------------------------------------
module wvd_div #(
  parameter int DEND_W = 32,
  parameter int DIV_W  = 7
) (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic [DEND_W-1:0] quotient
);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [DEND_W-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]    trial;
  logic              qbit;

  always_comb begin
    trial   = {rem_r, quo_r[DEND_W-1]};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
    quo_nxt = {quo_r[DEND_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

/* design/wvd_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvd_lane
// One axis: first/latest sample, square for the norm, serial velocity divide.
// ----------------------------------------------------------------------------
module wvd_lane #(
  parameter int WINDOW_MAX = wvd_pkg::WINDOW_MAX_DEF
) (
  input  logic                                   clk,
  input  wvd_pkg::ctl_t                          ctl,
  input  logic signed [wvd_pkg::POS_W-1:0]       pos,
  input  logic        [wvd_pkg::RATE_W-1:0]      rate,
  input  logic        [$clog2(WINDOW_MAX+1)-1:0] count,
  output logic        [wvd_pkg::SQ_W-1:0]        sq,
  output logic signed [wvd_pkg::VEL_W-1:0]       vel
);
  import wvd_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int PROD_W = POS_W + RATE_W + 2;

  logic signed [POS_W-1:0]  first_r, latest_r;
  logic        [SQ_W-1:0]   sq_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SQ_W-1:0]   sq_full;
  logic signed [POS_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic        [PROD_W-1:0] mag;
  logic        [VEL_W-1:0]  quo;

  assign sq_full = pos * pos;
  assign diff    = {latest_r[POS_W-1], latest_r} - {first_r[POS_W-1], first_r};
  assign prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, rate}));
  assign mag     = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.store) begin
      latest_r <= pos;
      sq_r     <= SQ_W'($unsigned(sq_full));
      if (ctl.first) begin
        first_r <= pos;
      end
    end
    if (ctl.mul) begin
      prod_r <= prod;
    end
  end

  wvd_div #(.DEND_W(VEL_W), .DIV_W(CNT_W)) u_div (
    .clk      (clk),
    .load     (ctl.div_load),
    .step     (ctl.div_step),
    .dividend (mag[VEL_W-1:0]),
    .divisor  (count),
    .quotient (quo)
  );

  always_comb begin
    if (prod_r[PROD_W-1]) begin
      if (quo > {1'b1, {(VEL_W-1){1'b0}}}) begin
        vel = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        vel = $signed(VEL_W'(-quo));
      end
    end else if (quo[VEL_W-1]) begin
      vel = {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      vel = $signed(quo);
    end
  end

  assign sq = sq_r;

endmodule

/* design/wvd_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvd_merge
// Combines lane squares: serial square root, norm sum, count, mean, direction.
// ----------------------------------------------------------------------------
module wvd_merge #(
  parameter int WINDOW_MAX = wvd_pkg::WINDOW_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wvd_pkg::ctl_t                          ctl,
  input  logic        [wvd_pkg::SQ_W-1:0]        sq_x,
  input  logic        [wvd_pkg::SQ_W-1:0]        sq_y,
  input  logic        [wvd_pkg::SQ_W-1:0]        sq_z,
  output wvd_pkg::stat_t                         stat,
  output logic        [$clog2(WINDOW_MAX+1)-1:0] count,
  output logic        [wvd_pkg::MEAN_W-1:0]      mean,
  output logic signed [wvd_pkg::DIR_W-1:0]       dir
);
  import wvd_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [NSUM_W-1:0] nsum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MEAN_W-1:0] prev_r;
  logic              have_prev_r;
  logic [REM_W+1:0]  rtry;
  logic [REM_W+1:0]  rbase;
  logic              rbit;
  logic [NSUM_W:0]   nsum_add;
  logic [VEL_W-1:0]  quo;

  always_comb begin
    rtry  = {rem_r, rad_r[SQ_W-1 -: 2]};
    rbase = (REM_W + 2)'({root_r, 2'b01});
    rbit  = (rtry >= rbase);
  end

  assign nsum_add = {1'b0, nsum_r} + (NSUM_W + 1)'(root_r);

  always_ff @(posedge clk) begin
    if (ctl.rad_load) begin
      rad_r  <= sq_x + sq_y + sq_z;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.root_step) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= rbit ? REM_W'(rtry - rbase) : REM_W'(rtry);
      root_r <= {root_r[ROOT_W-2:0], rbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsum_r      <= '0;
      cnt_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (ctl.close) begin
      nsum_r      <= '0;
      cnt_r       <= '0;
      prev_r      <= mean;
      have_prev_r <= 1'b1;
    end else if (ctl.acc) begin
      nsum_r <= nsum_add[NSUM_W] ? {NSUM_W{1'b1}} : nsum_add[NSUM_W-1:0];
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  wvd_div #(.DEND_W(VEL_W), .DIV_W(CNT_W)) u_div (
    .clk      (clk),
    .load     (ctl.div_load),
    .step     (ctl.div_step),
    .dividend (VEL_W'(nsum_r)),
    .divisor  (cnt_r),
    .quotient (quo)
  );

  assign mean = quo[MEAN_W-1:0];

  always_comb begin
    if (!have_prev_r || mean == prev_r) begin
      dir = DIR_FLAT;
    end else if (mean > prev_r) begin
      dir = DIR_UP;
    end else begin
      dir = DIR_DOWN;
    end
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(WINDOW_MAX));
  assign count      = cnt_r;

endmodule

/* design/window_velocity_direction.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_velocity_direction
// Per-window mean velocity, mean distance and direction from 3-D samples.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  in_ch    in   pos_x pos_y pos_z window_end
//  out_ch   out  vel_x vel_y vel_z mean_distance direction
//  cfg_ch   in   sample_rate_hz (always ready)
//
//  A stored sample is squared, then summed, 22-step square root, accumulate.
//  A closing sample then multiplies by the rate and runs the 32-step serial dividers.
//  A sample into a full window is not stored (closing: it still runs the dividers).
//  Result sits in an output register; next sample is taken while it waits.
//  rst_n is synchronous; clears window state, rate to 100, output empty.
module window_velocity_direction #(
  parameter int WINDOW_MAX = wvd_pkg::WINDOW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wvd_in_if.sink      in_ch,
  wvd_out_if.source   out_ch,
  wvd_cfg_if.sink     cfg_ch
);
  import wvd_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               wend_r;
  logic [RATE_W-1:0]  rate_r;
  ctl_t               ctl;
  stat_t              stat;
  logic [CNT_W-1:0]   count;
  logic               in_acc;
  logic               out_free;
  logic               out_valid_r;
  logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic signed [VEL_W-1:0] vx, vy, vz;
  logic [MEAN_W-1:0]  mean;
  logic signed [DIR_W-1:0] dir;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!stat.full) begin
            state_nxt = ST_SUM;
          end else if (in_ch.window_end) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC:  state_nxt = wend_r ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == STEP_W'(DIV_N - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign step_nxt = (state_nxt != state_r) ? '0 : step_r + 1'b1;

  always_comb begin
    ctl         = '0;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.store   = in_acc && !stat.full;
        ctl.first   = stat.empty;
      end
      ST_SUM:  ctl.rad_load  = 1'b1;
      ST_ROOT: ctl.root_step = 1'b1;
      ST_ACC:  ctl.acc       = 1'b1;
      ST_MUL:  ctl.mul       = 1'b1;
      ST_LOAD: ctl.div_load  = 1'b1;
      ST_DIV:  ctl.div_step  = 1'b1;
      ST_DONE: ctl.close     = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      rate_r      <= RATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_ch.valid) begin
        rate_r <= cfg_ch.sample_rate_hz;
      end
      if (ctl.close) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wend_r <= in_ch.window_end;
    end
    if (ctl.close) begin
      out_ch.vel_x         <= vx;
      out_ch.vel_y         <= vy;
      out_ch.vel_z         <= vz;
      out_ch.mean_distance <= mean;
      out_ch.direction     <= dir;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign cfg_ch.ready = 1'b1;

  wvd_lane #(.WINDOW_MAX(WINDOW_MAX)) u_lane_x (
    .clk (clk), .ctl (ctl), .pos (in_ch.pos_x), .rate (rate_r),
    .count (count), .sq (sq_x), .vel (vx)
  );

  wvd_lane #(.WINDOW_MAX(WINDOW_MAX)) u_lane_y (
    .clk (clk), .ctl (ctl), .pos (in_ch.pos_y), .rate (rate_r),
    .count (count), .sq (sq_y), .vel (vy)
  );

  wvd_lane #(.WINDOW_MAX(WINDOW_MAX)) u_lane_z (
    .clk (clk), .ctl (ctl), .pos (in_ch.pos_z), .rate (rate_r),
    .count (count), .sq (sq_z), .vel (vz)
  );

  wvd_merge #(.WINDOW_MAX(WINDOW_MAX)) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sq_x  (sq_x),
    .sq_y  (sq_y),
    .sq_z  (sq_z),
    .stat  (stat),
    .count (count),
    .mean  (mean),
    .dir   (dir)
  );

endmodule

/* design/wvd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvd_checker
// Port-level checks on the window velocity block, bound to the top level.
// ----------------------------------------------------------------------------
module wvd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [wvd_pkg::DIR_W-1:0]  direction
);
  import wvd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (direction == DIR_FLAT || direction == DIR_UP ||
                   direction == DIR_DOWN))
    else $error("bad direction code");

  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input side idle");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind window_velocity_direction wvd_checker u_wvd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .direction (out_ch.direction)
);
